### design/prime_field_alu_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prime field ALU
// Short forms for clocked implications, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef PRIME_FIELD_ALU_MACROS_SVH
`define PRIME_FIELD_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prime field ALU check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prime field ALU check failed");

`endif

### design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants and controller/datapath interface types of the field ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int MODULUS_RESET     = 65521;
    localparam int OP_WIDTH          = 3;

    localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_NEG = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_INV = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd5;

    typedef enum logic [1:0] {DIV_NONE, DIV_A, DIV_B, DIV_EU} t_div_sel;
    typedef enum logic [1:0] {MUL_NONE, MUL_AB, MUL_QC, MUL_AX} t_mul_sel;
    typedef enum logic [1:0] {EU_NONE, EU_A, EU_B} t_eu_sel;
    typedef enum logic [2:0] {FIN_ZERO, FIN_ADD, FIN_SUB, FIN_NEG, FIN_MUL, FIN_CH} t_fin;

    typedef enum logic [3:0] {
        S_IDLE, S_RA_INIT, S_RA_RUN, S_RB_INIT, S_RB_RUN, S_OPSEL,
        S_M_INIT, S_M_RUN, S_E_INIT, S_E_TEST, S_E_DIV, S_E_MINIT,
        S_E_MUL, S_E_UPD, S_X_INIT, S_FIN
    } t_state;

    typedef struct packed {
        logic     ld;
        t_div_sel div_init;
        logic     div_step;
        t_mul_sel mul_init;
        logic     mul_step;
        logic     save_a;
        logic     save_b;
        t_eu_sel  eu_init;
        logic     eu_upd;
        logic     res_wr;
        t_fin     fin;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic rl_zero;
        logic mod_small;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: reduction, operation select, multiply, Euclid loop and result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [pfa_pkg::OP_WIDTH-1:0] i_operation,
    input  wire pfa_pkg::t_dp_status         i_status,
    output pfa_pkg::t_dp_cmd                 o_cmd
);

    pfa_pkg::t_state                r_state, n_state;
    logic [pfa_pkg::OP_WIDTH-1:0]   r_op, n_op;
    pfa_pkg::t_fin                  r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
            r_op    <= pfa_pkg::OP_ADD;
            r_fin   <= pfa_pkg::FIN_ZERO;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_fin          = r_fin;
        o_cmd          = '0;
        o_cmd.div_init = pfa_pkg::DIV_NONE;
        o_cmd.mul_init = pfa_pkg::MUL_NONE;
        o_cmd.eu_init  = pfa_pkg::EU_NONE;
        o_cmd.fin      = r_fin;
        o_stall        = (r_state != pfa_pkg::S_IDLE);
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld = 1'b1;
                    n_op     = i_operation;
                    if (i_status.mod_small || i_operation > pfa_pkg::OP_DIV) begin
                        n_fin   = pfa_pkg::FIN_ZERO;
                        n_state = pfa_pkg::S_FIN;
                    end else begin
                        n_state = pfa_pkg::S_RA_INIT;
                    end
                end
            end
            pfa_pkg::S_RA_INIT: begin
                o_cmd.div_init = pfa_pkg::DIV_A;
                n_state        = pfa_pkg::S_RA_RUN;
            end
            pfa_pkg::S_RA_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last) n_state = pfa_pkg::S_RB_INIT;
            end
            pfa_pkg::S_RB_INIT: begin
                o_cmd.save_a   = 1'b1;
                o_cmd.div_init = pfa_pkg::DIV_B;
                n_state        = pfa_pkg::S_RB_RUN;
            end
            pfa_pkg::S_RB_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last) n_state = pfa_pkg::S_OPSEL;
            end
            pfa_pkg::S_OPSEL: begin
                o_cmd.save_b = 1'b1;
                priority if (r_op == pfa_pkg::OP_ADD) begin
                    n_fin = pfa_pkg::FIN_ADD; n_state = pfa_pkg::S_FIN;
                end else if (r_op == pfa_pkg::OP_SUB) begin
                    n_fin = pfa_pkg::FIN_SUB; n_state = pfa_pkg::S_FIN;
                end else if (r_op == pfa_pkg::OP_NEG) begin
                    n_fin = pfa_pkg::FIN_NEG; n_state = pfa_pkg::S_FIN;
                end else if (r_op == pfa_pkg::OP_MUL) begin
                    n_state = pfa_pkg::S_M_INIT;
                end else begin
                    n_state = pfa_pkg::S_E_INIT;
                end
            end
            pfa_pkg::S_M_INIT: begin
                o_cmd.mul_init = pfa_pkg::MUL_AB;
                n_state        = pfa_pkg::S_M_RUN;
            end
            pfa_pkg::S_M_RUN: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.last) begin
                    n_fin   = pfa_pkg::FIN_MUL;
                    n_state = pfa_pkg::S_FIN;
                end
            end
            pfa_pkg::S_E_INIT: begin
                o_cmd.eu_init = (r_op == pfa_pkg::OP_INV) ? pfa_pkg::EU_A : pfa_pkg::EU_B;
                n_state       = pfa_pkg::S_E_TEST;
            end
            pfa_pkg::S_E_TEST: begin
                if (i_status.rl_zero) begin
                    if (r_op == pfa_pkg::OP_INV) begin
                        n_fin   = pfa_pkg::FIN_CH;
                        n_state = pfa_pkg::S_FIN;
                    end else begin
                        n_state = pfa_pkg::S_X_INIT;
                    end
                end else begin
                    o_cmd.div_init = pfa_pkg::DIV_EU;
                    n_state        = pfa_pkg::S_E_DIV;
                end
            end
            pfa_pkg::S_E_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last) n_state = pfa_pkg::S_E_MINIT;
            end
            pfa_pkg::S_E_MINIT: begin
                o_cmd.mul_init = pfa_pkg::MUL_QC;
                n_state        = pfa_pkg::S_E_MUL;
            end
            pfa_pkg::S_E_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.last) n_state = pfa_pkg::S_E_UPD;
            end
            pfa_pkg::S_E_UPD: begin
                o_cmd.eu_upd = 1'b1;
                n_state      = pfa_pkg::S_E_TEST;
            end
            pfa_pkg::S_X_INIT: begin
                o_cmd.mul_init = pfa_pkg::MUL_AX;
                n_state        = pfa_pkg::S_M_RUN;
            end
            pfa_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.res_wr = 1'b1;
                    n_state      = pfa_pkg::S_IDLE;
                end
            end
            default: n_state = pfa_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Modulus register, bit-serial divider, double-and-add modular multiplier,
// Euclid registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "prime_field_alu_macros.svh"

module pfa_datapath #(
    parameter int ELEMENT_WIDTH = pfa_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [ELEMENT_WIDTH-1:0] i_cfg_wr_data,
    input  wire logic [ELEMENT_WIDTH-1:0] i_lhs,
    input  wire logic [ELEMENT_WIDTH-1:0] i_rhs,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output logic [ELEMENT_WIDTH-1:0]      o_result,
    input  wire pfa_pkg::t_dp_cmd         i_cmd,
    output pfa_pkg::t_dp_status           o_status
);

    localparam int W  = ELEMENT_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_mod;
    logic          r_o_valid;
    logic [W-1:0]  r_result;
    logic [W-1:0]  r_lhs, r_rhs, r_a, r_b;
    logic [W-1:0]  r_num, r_den, r_rem, r_quo;
    logic [W-1:0]  r_acc, r_mplier, r_mcand;
    logic [W-1:0]  r_rh, r_rl, r_ch, r_cl;
    logic [CW-1:0] r_cnt;

    logic [W:0]    mod_x;
    logic [W:0]    div_sh, div_diff;
    logic          div_ge;
    logic [W-1:0]  div_rem_n;
    logic [W:0]    dbl, dbl_r, sum, sum_r;
    logic [W-1:0]  mul_acc_n;
    logic [W:0]    eu_ext;
    logic [W:0]    add_s, sub_s;
    logic [W-1:0]  fin_val;
    logic          out_free;

    assign mod_x = {1'b0, r_mod};

    // One restoring-division bit per cycle.
    assign div_sh    = {r_rem, r_num[W-1]};
    assign div_diff  = div_sh - {1'b0, r_den};
    assign div_ge    = (div_sh >= {1'b0, r_den});
    assign div_rem_n = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];

    // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*mcand (mod p).
    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= mod_x) ? dbl - mod_x : dbl;
        sum   = dbl_r + (r_mplier[W-1] ? {1'b0, r_mcand} : '0);
        sum_r = (sum >= mod_x) ? sum - mod_x : sum;
    end
    assign mul_acc_n = sum_r[W-1:0];

    // Next Euclid coefficient, kept reduced: ch - q*cl (mod p).
    assign eu_ext = {1'b0, r_ch} + ((r_ch >= r_acc) ? '0 : mod_x) - {1'b0, r_acc};

    assign add_s = {1'b0, r_a} + {1'b0, r_b};
    assign sub_s = {1'b0, r_a} + ((r_a >= r_b) ? '0 : mod_x) - {1'b0, r_b};

    always_comb begin
        unique case (i_cmd.fin)
            pfa_pkg::FIN_ZERO: fin_val = '0;
            pfa_pkg::FIN_ADD:  fin_val = (add_s >= mod_x) ? W'(add_s - mod_x) : add_s[W-1:0];
            pfa_pkg::FIN_SUB:  fin_val = sub_s[W-1:0];
            pfa_pkg::FIN_NEG:  fin_val = (r_a == '0) ? '0 : r_mod - r_a;
            pfa_pkg::FIN_MUL:  fin_val = r_acc;
            pfa_pkg::FIN_CH:   fin_val = r_ch;
            default:           fin_val = '0;
        endcase
    end

    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= W'(pfa_pkg::MODULUS_RESET);
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_mod <= i_cfg_wr_data;
            if (i_cmd.res_wr) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_lhs <= i_lhs;
            r_rhs <= i_rhs;
        end
        if (i_cmd.div_init != pfa_pkg::DIV_NONE) begin
            r_rem <= '0;
            r_cnt <= CW'(W - 1);
            unique case (i_cmd.div_init)
                pfa_pkg::DIV_A:  begin r_num <= r_lhs; r_den <= r_mod; end
                pfa_pkg::DIV_B:  begin r_num <= r_rhs; r_den <= r_mod; end
                pfa_pkg::DIV_EU: begin r_num <= r_rh;  r_den <= r_rl;  end
                default:         begin r_num <= r_lhs; r_den <= r_mod; end
            endcase
        end
        if (i_cmd.div_step) begin
            r_rem <= div_rem_n;
            r_num <= {r_num[W-2:0], 1'b0};
            r_quo <= {r_quo[W-2:0], div_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul_init != pfa_pkg::MUL_NONE) begin
            r_acc <= '0;
            r_cnt <= CW'(W - 1);
            unique case (i_cmd.mul_init)
                pfa_pkg::MUL_AB: begin r_mplier <= r_b;   r_mcand <= r_a;  end
                pfa_pkg::MUL_QC: begin r_mplier <= r_quo; r_mcand <= r_cl; end
                pfa_pkg::MUL_AX: begin r_mplier <= r_ch;  r_mcand <= r_a;  end
                default:         begin r_mplier <= r_b;   r_mcand <= r_a;  end
            endcase
        end
        if (i_cmd.mul_step) begin
            r_acc    <= mul_acc_n;
            r_mplier <= {r_mplier[W-2:0], 1'b0};
            r_cnt    <= r_cnt - 1'b1;
        end
        if (i_cmd.save_a) r_a <= r_rem;
        if (i_cmd.save_b) r_b <= r_rem;
        unique case (i_cmd.eu_init)
            pfa_pkg::EU_A: begin
                r_rh <= r_mod; r_rl <= r_a; r_ch <= '0; r_cl <= W'(1);
            end
            pfa_pkg::EU_B: begin
                r_rh <= r_mod; r_rl <= r_b; r_ch <= '0; r_cl <= W'(1);
            end
            default: ;
        endcase
        if (i_cmd.eu_upd) begin
            r_rh <= r_rl;
            r_rl <= r_rem;
            r_ch <= r_cl;
            r_cl <= eu_ext[W-1:0];
        end
        if (i_cmd.res_wr) r_result <= fin_val;
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_result;

    assign o_status.last      = (r_cnt == '0);
    assign o_status.rl_zero   = (r_rl == '0);
    assign o_status.mod_small = (r_mod < W'(2));
    assign o_status.out_free  = out_free;

    `PFA_ASSERT_SAME(a_write_free, i_cmd.res_wr, out_free)
    `PFA_ASSERT_NEXT(a_red_a_below_p, i_cmd.save_a, r_a < r_mod)
    `PFA_ASSERT_NEXT(a_acc_below_p, i_cmd.mul_step, r_acc < r_mod)

endmodule

`default_nettype wire

### design/prime_field_alu.sv
// ----------------------------------------------------------------------------
// prime_field_alu
// Add, subtract, negate, multiply, inverse and divide over GF(p).
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_operation, i_lhs, i_rhs) is taken when i_valid is high and
//   o_stall is low. One result per request appears on o_result with o_valid
//   and is taken when i_stall is low. The modulus must be written through
//   i_cfg_wr_en / i_cfg_wr_data only while the unit is idle; the block does
//   not enforce this. With W = ELEMENT_WIDTH, both operands are reduced by a
//   one-bit-per-cycle divider, one after the other; add, subtract and negate
//   then write their result, and the next request is taken in the cycle
//   after that write. Multiply adds a pass of the serial double-and-add
//   multiplier. Inverse adds k Euclid rounds, each a test, a division, a
//   multiply of the quotient by a coefficient and an update, k being the
//   number of division steps of Euclid on (p, a); divide runs the rounds on
//   (p, b) and adds one multiply on top.
//   One request is in work at a time; the output register lets the next
//   request be taken while a result waits under i_stall, and the final
//   write waits only for that register to free up.
//   Reset clears the sequencer and the output valid and loads p = 65521.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prime_field_alu #(
    parameter int ELEMENT_WIDTH = pfa_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [ELEMENT_WIDTH-1:0]     i_cfg_wr_data,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [pfa_pkg::OP_WIDTH-1:0] i_operation,
    input  wire logic [ELEMENT_WIDTH-1:0]     i_lhs,
    input  wire logic [ELEMENT_WIDTH-1:0]     i_rhs,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [ELEMENT_WIDTH-1:0]          o_result
);

    pfa_pkg::t_dp_cmd    cmd;
    pfa_pkg::t_dp_status status;

    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pfa_datapath #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_lhs         (i_lhs),
        .i_rhs         (i_rhs),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_result      (o_result),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

`default_nettype wire

### dv/prime_field_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_alu_checker
// Watches the request and result channels of the field ALU, computes the
// expected field result of each accepted request and compares it in order.
// ----------------------------------------------------------------------------
module prime_field_alu_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [15:0]                  i_cfg_wr_data,
    input  logic                         i_valid,
    input  logic                         i_stall_in,
    input  logic [pfa_pkg::OP_WIDTH-1:0] i_operation,
    input  logic [15:0]                  i_lhs,
    input  logic [15:0]                  i_rhs,
    input  logic                         i_out_valid,
    input  logic                         i_stall_out,
    input  logic [15:0]                  i_result,
    output int                           o_errors,
    output int                           o_pending,
    output logic                         o_progress
);

    logic [15:0] field_p;
    logic [15:0] expected_results[$];

    // Extended Euclid coefficient x with x*a == gcd(a, p) mod p.
    function automatic longint unsigned euclid_coef(longint unsigned a, longint unsigned p);
        longint r_hi, r_lo, c_hi, c_lo, q, t;
        r_hi = p; r_lo = a; c_hi = 0; c_lo = 1;
        while (r_lo != 0) begin
            q = r_hi / r_lo;
            t = r_hi - q * r_lo; r_hi = r_lo; r_lo = t;
            t = c_hi - q * c_lo; c_hi = c_lo; c_lo = t;
        end
        if (c_hi < 0) c_hi += p;
        return longint'(c_hi) % p;
    endfunction

    function automatic logic [15:0] field_result(logic [2:0] op, logic [15:0] lhs,
                                                 logic [15:0] rhs, logic [15:0] pm);
        longint unsigned p, a, b, r;
        p = pm;
        if (p < 2) return '0;
        a = lhs % p;
        b = rhs % p;
        case (op)
            pfa_pkg::OP_ADD: r = (a + b) % p;
            pfa_pkg::OP_SUB: r = (p + a - b) % p;
            pfa_pkg::OP_NEG: r = (p - a) % p;
            pfa_pkg::OP_MUL: r = (a * b) % p;
            pfa_pkg::OP_INV: r = euclid_coef(a, p);
            pfa_pkg::OP_DIV: r = (a * euclid_coef(b, p)) % p;
            default: r = 0;
        endcase
        return r[15:0];
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        logic [15:0] exp_val;
        logic        seen;
        seen = 1'b0;
        if (!i_rst_n) begin
            field_p  <= 16'(pfa_pkg::MODULUS_RESET);
            o_errors <= 0;
        end else begin
            if (i_cfg_wr_en) field_p <= i_cfg_wr_data;
            if (i_valid && !i_stall_in) begin
                expected_results.push_back(field_result(i_operation, i_lhs, i_rhs, field_p));
                seen = 1'b1;
            end
            if (i_out_valid && !i_stall_out) begin
                seen = 1'b1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) $display("Unexpected result %0d", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_val = expected_results.pop_front();
                    if (exp_val !== i_result) begin
                        if (o_errors < 10)
                            $display("Mismatch: expected %0d, got %0d", exp_val, i_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_progress <= seen;
    end
endmodule

### dv/prime_field_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_alu_tb
// Drives directed and random requests through several moduli, with random
// request gaps and output stalls; a checker compares every result.
// ----------------------------------------------------------------------------
module prime_field_alu_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  req_op = '0;
    logic [15:0] req_lhs = '0;
    logic [15:0] req_rhs = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] res_value;
    int          errors, pending, idle_cycles, n_items;
    int          stall_left = 0;
    logic        progress;
    logic [15:0] cur_p;
    bit          long_stall_mode;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    prime_field_alu uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_operation(req_op), .i_lhs(req_lhs), .i_rhs(req_rhs),
        .o_valid(res_valid), .i_stall(res_stall), .o_result(res_value)
    );

    prime_field_alu_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_valid(req_valid), .i_stall_in(req_stall),
        .i_operation(req_op), .i_lhs(req_lhs), .i_rhs(req_rhs),
        .i_out_valid(res_valid), .i_stall_out(res_stall), .i_result(res_value),
        .o_errors(errors), .o_pending(pending), .o_progress(progress)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // In the stalling phases the receiver stalls in bursts, mostly short.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (long_stall_mode && $urandom_range(0, 7) == 0) begin
            res_stall  <= 1'b1;
            stall_left <= gap_length();
        end else begin
            res_stall  <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || progress) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Biased operand: mostly below p, sometimes extremes or not reduced.
    function automatic logic [15:0] pick_operand(logic [15:0] pm);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return (pm == 0) ? 16'd0 : pm - 16'd1;
            2: return 16'($urandom());
            3: return 16'd1;
            default: return (pm < 2) ? 16'($urandom()) : 16'($urandom_range(0, pm - 1));
        endcase
    endfunction

    // Valid stays high after acceptance when no gap follows; the unit is
    // busy for the next cycles, so the new request simply waits.
    task automatic send_request(logic [2:0] op, logic [15:0] lhs, logic [15:0] rhs);
        int gap;
        gap = gap_length();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_lhs   <= lhs;
        req_rhs   <= rhs;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        n_items++;
    endtask

    task automatic set_modulus(logic [15:0] pm);
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || req_stall) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pm;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        cur_p = pm;
    endtask

    task automatic random_phase(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            send_request(op, pick_operand(cur_p), pick_operand(cur_p));
        end
    endtask

    initial begin
        logic [15:0] primes[6];
        primes = '{16'd65521, 16'd2, 16'd3, 16'd65519, 16'd251, 16'd7919};
        n_items = 0;
        cur_p = 16'(pfa_pkg::MODULUS_RESET);
        long_stall_mode = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, zero inverse and divide.
        send_request(pfa_pkg::OP_ADD, 16'd65520, 16'd65520);
        send_request(pfa_pkg::OP_SUB, 16'd0, 16'd65520);
        send_request(pfa_pkg::OP_SUB, 16'd65520, 16'd0);
        send_request(pfa_pkg::OP_NEG, 16'd0, 16'hFFFF);
        send_request(pfa_pkg::OP_NEG, 16'd1, 16'd0);
        send_request(pfa_pkg::OP_MUL, 16'd65520, 16'd65520);
        send_request(pfa_pkg::OP_INV, 16'd0, 16'd0);
        send_request(pfa_pkg::OP_INV, 16'd1, 16'd0);
        send_request(pfa_pkg::OP_INV, 16'd65520, 16'd0);
        send_request(pfa_pkg::OP_DIV, 16'd1234, 16'd0);
        send_request(pfa_pkg::OP_DIV, 16'd65520, 16'd3);
        send_request(pfa_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
        send_request(pfa_pkg::OP_MUL, 16'hFFFF, 16'd65521);
        send_request(3'd6, 16'd5, 16'd5);
        send_request(3'd7, 16'hFFFF, 16'hFFFF);

        // Degenerate and composite moduli.
        set_modulus(16'd0);
        send_request(pfa_pkg::OP_MUL, 16'd3, 16'd4);
        send_request(pfa_pkg::OP_INV, 16'd3, 16'd0);
        set_modulus(16'd1);
        send_request(pfa_pkg::OP_ADD, 16'd3, 16'd4);
        set_modulus(16'hFFFF);
        send_request(pfa_pkg::OP_INV, 16'd6, 16'd0);
        send_request(pfa_pkg::OP_DIV, 16'd7, 16'd10);
        send_request(pfa_pkg::OP_INV, 16'hFFFF, 16'd0);

        for (int k = 0; k < 6; k++) begin
            set_modulus(primes[k]);
            long_stall_mode = (k % 2 == 1);
            random_phase(300);
        end
        set_modulus(16'($urandom_range(0, 65535)));
        random_phase(150);

        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests over the reset modulus and ten written ones,", n_items);
        $display("degenerate and composite included, with random gaps and output stalls.");
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
